// ----- src/tgq_pkg.sv -----
// ----------------------------------------------------------------------------
// tgq_pkg: shared types and codes for the team grouped queue
// Item and result layouts, operation and status codes, and the command that
// the front end hands to the queue engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tgq_pkg;

    // Default sizing
    localparam int NUM_TEAMS_DEF       = 64;
    localparam int NUM_ELEMENT_IDS_DEF = 1024;
    localparam int QUEUE_CAPACITY_DEF  = 256;

    // Widest team number any configuration needs
    localparam int TEAM_FIELD_W = 10;

    // Operation codes
    localparam logic [1:0] OP_BIND = 2'd0;
    localparam logic [1:0] OP_ENQ  = 2'd1;
    localparam logic [1:0] OP_DEQ  = 2'd2;

    // Status codes
    localparam logic [2:0] ST_DONE    = 3'd0;
    localparam logic [2:0] ST_DEQ_OK  = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_NO_TEAM = 3'd4;

    // Command kinds
    localparam logic [1:0] CMD_STATUS = 2'd0;
    localparam logic [1:0] CMD_ENQ    = 2'd1;
    localparam logic [1:0] CMD_DEQ    = 2'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [9:0] element_id;
        logic [5:0] team_id;
    } item_t;

    typedef struct packed {
        logic [9:0] out_element;
        logic [2:0] status;
    } result_t;

    typedef struct packed {
        logic [1:0]              kind;
        logic [2:0]              status;
        logic [9:0]              element_id;
        logic [TEAM_FIELD_W-1:0] team;
    } cmd_t;

endpackage

// ----- src/tgq_ram.sv -----
// ----------------------------------------------------------------------------
// tgq_ram: generic single write port RAM
// One write and one registered read per cycle; read data holds without re.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/tgq_front.sv -----
// ----------------------------------------------------------------------------
// tgq_front: item intake and classification
// Holds the membership table, clears it after reset, applies binds and turns
// each item into a command for the queue engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgq_front #(
    parameter int NUM_TEAMS       = tgq_pkg::NUM_TEAMS_DEF,
    parameter int NUM_ELEMENT_IDS = tgq_pkg::NUM_ELEMENT_IDS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  tgq_pkg::item_t item,
    output logic          cmd_push,
    input  logic          cmd_full,
    output tgq_pkg::cmd_t  cmd
);
    import tgq_pkg::*;

    localparam int EW = $clog2(NUM_ELEMENT_IDS);
    localparam int TW = $clog2(NUM_TEAMS);
    localparam logic [EW:0] N_IDS = (EW+1)'(NUM_ELEMENT_IDS);

    logic [EW:0]   clr_reg, clr_next;
    logic          clearing;
    logic          stg_valid_reg, stg_valid_next;
    item_t         stg_reg;
    logic          accept;
    logic [31:0]   eid_wide, tid_wide, stg_eid_wide;
    logic          bind_ok;
    logic          ram_we;
    logic [EW-1:0] ram_waddr;
    logic [TW:0]   ram_wdata, ram_rdata;

    assign clearing = (clr_reg != N_IDS);
    assign full     = clearing || stg_valid_reg;
    assign accept   = push && !full;

    assign eid_wide     = 32'(item.element_id);
    assign tid_wide     = 32'(item.team_id);
    assign stg_eid_wide = 32'(stg_reg.element_id);
    assign bind_ok      = (item.opcode == OP_BIND) && (eid_wide < NUM_ELEMENT_IDS)
                          && (tid_wide < NUM_TEAMS);

    // Table write: clearing sweep first, then binds
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = eid_wide[EW-1:0];
        ram_wdata = {1'b1, tid_wide[TW-1:0]};
        if (clearing)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg[EW-1:0];
            ram_wdata = '0;
        end
        else if (accept && bind_ok)
        begin
            ram_we = 1'b1;
        end
    end

    assign clr_next = clearing ? clr_reg + 1'b1 : clr_reg;

    tgq_ram #(.WIDTH(TW+1), .DEPTH(NUM_ELEMENT_IDS)) u_member (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (eid_wide[EW-1:0]),
        .rdata (ram_rdata)
    );

    // Classify the staged item
    always_comb
    begin
        cmd            = '0;
        cmd.kind       = CMD_STATUS;
        cmd.status     = ST_DONE;
        cmd.element_id = stg_reg.element_id;
        cmd.team       = TEAM_FIELD_W'(ram_rdata[TW-1:0]);
        unique case (stg_reg.opcode)
            OP_ENQ:
            begin
                if ((stg_eid_wide >= NUM_ELEMENT_IDS) || !ram_rdata[TW])
                begin
                    cmd.status = ST_NO_TEAM;
                end
                else
                begin
                    cmd.kind = CMD_ENQ;
                end
            end
            OP_DEQ:
            begin
                cmd.kind = CMD_DEQ;
            end
            default:
            begin
                cmd.kind = CMD_STATUS;
            end
        endcase
    end

    assign cmd_push = stg_valid_reg && !cmd_full;

    always_comb
    begin
        stg_valid_next = stg_valid_reg;
        if (accept)
        begin
            stg_valid_next = 1'b1;
        end
        else if (cmd_push)
        begin
            stg_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            clr_reg       <= clr_next;
            stg_valid_reg <= stg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stg_reg <= item;
        end
    end

endmodule

// ----- src/tgq_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// tgq_cmd_fifo: two-entry command queue
// Decouples the front end from the queue engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgq_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    output logic          full,
    input  tgq_pkg::cmd_t  wdata,
    input  logic          rd,
    output logic          empty,
    output tgq_pkg::cmd_t  rdata
);
    import tgq_pkg::*;

    cmd_t       mem_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign rdata = mem_reg[rp_reg];

    // Pointer and count update
    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (wr && !full)
        begin
            wp_next = !wp_reg;
        end
        if (rd && !empty)
        begin
            rp_next = !rp_reg;
        end
        if ((wr && !full) && !(rd && !empty))
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!(wr && !full) && (rd && !empty))
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr && !full)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

endmodule

// ----- src/tgq_engine.sv -----
// ----------------------------------------------------------------------------
// tgq_engine: linked queue engine
// Carries out enqueue and dequeue on the node memories with a small
// sequencer, and holds the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgq_engine #(
    parameter int NUM_TEAMS      = tgq_pkg::NUM_TEAMS_DEF,
    parameter int QUEUE_CAPACITY = tgq_pkg::QUEUE_CAPACITY_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_empty,
    input  tgq_pkg::cmd_t    cmd,
    output logic            cmd_pop,
    output logic            empty,
    input  logic            pop,
    output tgq_pkg::result_t result
);
    import tgq_pkg::*;

    localparam int AW = $clog2(QUEUE_CAPACITY);
    localparam int TW = $clog2(NUM_TEAMS);
    localparam logic [AW:0] CAP = (AW+1)'(QUEUE_CAPACITY);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ENQ1 = 3'd1;
    localparam logic [2:0] S_ENQ2 = 3'd2;
    localparam logic [2:0] S_ENQ3 = 3'd3;
    localparam logic [2:0] S_DEQ1 = 3'd4;
    localparam logic [2:0] S_DEQ2 = 3'd5;
    localparam logic [2:0] S_ENQ4 = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [AW-1:0]       head_reg, head_next, tail_reg, tail_next;
    logic [AW-1:0]       n_reg, n_next, p_reg, p_next;
    logic [AW:0]         count_reg, count_next, sp_reg, sp_next, alloc_reg, alloc_next;
    logic [NUM_TEAMS-1:0] tlv_reg, tlv_next;
    logic [9:0]          eid_reg, eid_next;
    logic [TW-1:0]       t_reg, t_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg, out_next;
    logic [AW:0]         sp_dec;
    logic [TW-1:0]       cmd_t_idx;
    logic [AW-1:0]       n_sel;

    // Memory ports
    logic          val_we, lnk_we, tm_we, tl_we, stk_we;
    logic          val_re, lnk_re, tm_re, tl_re, stk_re;
    logic [AW-1:0] val_waddr, lnk_waddr, tm_waddr, stk_waddr;
    logic [AW-1:0] val_raddr, lnk_raddr, tm_raddr, stk_raddr;
    logic [TW-1:0] tl_waddr, tl_raddr;
    logic [9:0]    val_wdata, val_rdata;
    logic [AW-1:0] lnk_wdata, lnk_rdata, tl_wdata, tl_rdata, stk_wdata, stk_rdata;
    logic [TW-1:0] tm_wdata, tm_rdata;

    assign sp_dec    = sp_reg - 1'b1;
    assign cmd_t_idx = cmd.team[TW-1:0];
    assign n_sel     = (sp_reg != '0) ? stk_rdata : alloc_reg[AW-1:0];
    assign empty     = !out_valid_reg;
    assign result    = out_reg;

    tgq_ram #(.WIDTH(10), .DEPTH(QUEUE_CAPACITY)) u_value (
        .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
        .re(val_re), .raddr(val_raddr), .rdata(val_rdata)
    );
    tgq_ram #(.WIDTH(AW), .DEPTH(QUEUE_CAPACITY)) u_link (
        .clk(clk), .we(lnk_we), .waddr(lnk_waddr), .wdata(lnk_wdata),
        .re(lnk_re), .raddr(lnk_raddr), .rdata(lnk_rdata)
    );
    tgq_ram #(.WIDTH(TW), .DEPTH(QUEUE_CAPACITY)) u_team (
        .clk(clk), .we(tm_we), .waddr(tm_waddr), .wdata(tm_wdata),
        .re(tm_re), .raddr(tm_raddr), .rdata(tm_rdata)
    );
    tgq_ram #(.WIDTH(AW), .DEPTH(NUM_TEAMS)) u_last (
        .clk(clk), .we(tl_we), .waddr(tl_waddr), .wdata(tl_wdata),
        .re(tl_re), .raddr(tl_raddr), .rdata(tl_rdata)
    );
    tgq_ram #(.WIDTH(AW), .DEPTH(QUEUE_CAPACITY)) u_free (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .re(stk_re), .raddr(stk_raddr), .rdata(stk_rdata)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        n_next         = n_reg;
        p_next         = p_reg;
        count_next     = count_reg;
        sp_next        = sp_reg;
        alloc_next     = alloc_reg;
        tlv_next       = tlv_reg;
        eid_next       = eid_reg;
        t_next         = t_reg;
        out_valid_next = out_valid_reg && !pop;
        out_next       = out_reg;
        cmd_pop        = 1'b0;

        val_we = 1'b0; val_waddr = n_sel;    val_wdata = eid_reg;
        tm_we  = 1'b0; tm_waddr  = n_sel;    tm_wdata  = t_reg;
        lnk_we = 1'b0; lnk_waddr = tail_reg; lnk_wdata = n_sel;
        tl_we  = 1'b0; tl_waddr  = t_reg;    tl_wdata  = n_sel;
        stk_we = 1'b0; stk_waddr = sp_reg[AW-1:0]; stk_wdata = head_reg;
        val_re = 1'b0; val_raddr = head_reg;
        tm_re  = 1'b0; tm_raddr  = head_reg;
        lnk_re = 1'b0; lnk_raddr = head_reg;
        tl_re  = 1'b0; tl_raddr  = cmd_t_idx;
        stk_re = 1'b0; stk_raddr = sp_dec[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                // A result leaving this cycle frees the result register
                if (!cmd_empty && (!out_valid_reg || pop))
                begin
                    cmd_pop  = 1'b1;
                    eid_next = cmd.element_id;
                    t_next   = cmd_t_idx;
                    unique case (cmd.kind)
                        CMD_ENQ:
                        begin
                            if (count_reg == CAP)
                            begin
                                out_valid_next = 1'b1;
                                out_next       = '{out_element: '0, status: ST_FULL};
                            end
                            else
                            begin
                                stk_re     = 1'b1;
                                tl_re      = 1'b1;
                                state_next = S_ENQ1;
                            end
                        end
                        CMD_DEQ:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                out_next       = '{out_element: '0, status: ST_EMPTY};
                            end
                            else
                            begin
                                val_re     = 1'b1;
                                tm_re      = 1'b1;
                                lnk_re     = 1'b1;
                                state_next = S_DEQ1;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            out_next       = '{out_element: '0, status: cmd.status};
                        end
                    endcase
                end
            end
            S_ENQ1:
            begin
                // Allocate a node and write its payload
                n_next = n_sel;
                if (sp_reg != '0)
                begin
                    sp_next = sp_dec;
                end
                else
                begin
                    alloc_next = alloc_reg + 1'b1;
                end
                val_we          = 1'b1;
                tm_we           = 1'b1;
                tl_we           = 1'b1;
                tlv_next[t_reg] = 1'b1;
                if (count_reg == '0)
                begin
                    head_next  = n_sel;
                    tail_next  = n_sel;
                    state_next = S_ENQ3;
                end
                else if (!tlv_reg[t_reg])
                begin
                    lnk_we     = 1'b1;
                    tail_next  = n_sel;
                    state_next = S_ENQ3;
                end
                else
                begin
                    p_next     = tl_rdata;
                    lnk_re     = 1'b1;
                    lnk_raddr  = tl_rdata;
                    state_next = S_ENQ2;
                end
            end
            S_ENQ2:
            begin
                // New node takes the successor of its teammate
                lnk_we     = 1'b1;
                lnk_waddr  = n_reg;
                lnk_wdata  = lnk_rdata;
                state_next = S_ENQ4;
            end
            S_ENQ3:
            begin
                // Count the new node and finish
                count_next     = count_reg + 1'b1;
                out_valid_next = 1'b1;
                out_next       = '{out_element: '0, status: ST_DONE};
                state_next     = S_IDLE;
            end
            S_DEQ1:
            begin
                tl_re      = 1'b1;
                tl_raddr   = tm_rdata;
                state_next = S_DEQ2;
            end
            S_DEQ2:
            begin
                if (tlv_reg[tm_rdata] && (tl_rdata == head_reg))
                begin
                    tlv_next[tm_rdata] = 1'b0;
                end
                stk_we         = 1'b1;
                sp_next        = sp_reg + 1'b1;
                head_next      = lnk_rdata;
                count_next     = count_reg - 1'b1;
                out_valid_next = 1'b1;
                out_next       = '{out_element: val_rdata, status: ST_DEQ_OK};
                state_next     = S_IDLE;
            end
            S_ENQ4:
            begin
                // Point the teammate at the new node
                lnk_we    = 1'b1;
                lnk_waddr = p_reg;
                lnk_wdata = n_reg;
                if (tail_reg == p_reg)
                begin
                    tail_next = n_reg;
                end
                count_next     = count_reg + 1'b1;
                out_valid_next = 1'b1;
                out_next       = '{out_element: '0, status: ST_DONE};
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            sp_reg        <= '0;
            alloc_reg     <= '0;
            tlv_reg       <= '0;
            out_valid_reg <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sp_reg        <= sp_next;
            alloc_reg     <= alloc_next;
            tlv_reg       <= tlv_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        p_reg   <= p_next;
        eid_reg <= eid_next;
        t_reg   <= t_next;
        out_reg <= out_next;
    end

endmodule

// ----- src/team_grouped_queue_top.sv -----
// ----------------------------------------------------------------------------
// team_grouped_queue_top: team queue of element ids
// Front end, command queue and linked queue engine.
// ----------------------------------------------------------------------------
// The front end takes no new item while one is staged: it reads the
// membership table (a registered read) and hands a command on. The engine
// ends a status-only item in S_IDLE, runs a dequeue through S_DEQ1 and
// S_DEQ2, an enqueue that appends at the tail through S_ENQ1 and S_ENQ3,
// and one behind a queued teammate through S_ENQ1, S_ENQ2 and S_ENQ4; node
// memories with one write port set these steps. After reset the membership
// table is swept clear, one entry a cycle, and full stays high until it ends.
`timescale 1ns / 1ps

module team_grouped_queue_top #(
    parameter int NUM_TEAMS       = tgq_pkg::NUM_TEAMS_DEF,
    parameter int NUM_ELEMENT_IDS = tgq_pkg::NUM_ELEMENT_IDS_DEF,
    parameter int QUEUE_CAPACITY  = tgq_pkg::QUEUE_CAPACITY_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  tgq_pkg::item_t    item,
    output logic             empty,
    input  logic             pop,
    output tgq_pkg::result_t  result
);
    import tgq_pkg::*;

    cmd_t fe_cmd, be_cmd;
    logic fe_push, q_full, q_empty, be_pop;

    tgq_front #(.NUM_TEAMS(NUM_TEAMS), .NUM_ELEMENT_IDS(NUM_ELEMENT_IDS)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .item(item),
        .cmd_push(fe_push), .cmd_full(q_full), .cmd(fe_cmd)
    );

    tgq_cmd_fifo u_fifo (
        .clk(clk), .rst_n(rst_n), .wr(fe_push), .full(q_full), .wdata(fe_cmd),
        .rd(be_pop), .empty(q_empty), .rdata(be_cmd)
    );

    tgq_engine #(.NUM_TEAMS(NUM_TEAMS), .QUEUE_CAPACITY(QUEUE_CAPACITY)) u_engine (
        .clk(clk), .rst_n(rst_n), .cmd_empty(q_empty), .cmd(be_cmd),
        .cmd_pop(be_pop), .empty(empty), .pop(pop), .result(result)
    );

endmodule

// ----- verif/team_grouped_queue_top_tb.sv -----
// ----------------------------------------------------------------------------
// team_grouped_queue_top_tb: regression bench for the team grouped queue
// Binds, enqueues and dequeues go in through the push side; a behavioral
// team queue predicts every result and the pop side checks them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module team_grouped_queue_top_tb;

    import tgq_pkg::*;

    localparam int N_IDS       = 1024;
    localparam int CAPACITY    = 256;
    localparam int IDLE_LIMIT  = 20000;
    localparam int HOLD_CYCLES = 3000;

    logic    clk;
    logic    rst_n;
    logic    push;
    logic    full;
    item_t   item;
    logic    empty;
    logic    pop;
    result_t result;

    team_grouped_queue_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    // Predicted team queue contents
    bit   [6:0]  elem_team [N_IDS];   // bit 6 = bound
    logic [9:0]  q_elem [$];
    logic [5:0]  q_team [$];

    item_t   pending_items [$];
    result_t expected_results [$];

    int  errors;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  recv_hold;
    int  hold_cnt;
    int  idle_cycles;

    // Predict the result of one accepted item
    function automatic result_t predict_team_queue(item_t it);
        result_t r;
        int      pos;
        r = '0;
        r.status = ST_DONE;
        if (it.opcode == OP_BIND)
        begin
            elem_team[it.element_id] = {1'b1, it.team_id};
        end
        else if (it.opcode == OP_ENQ)
        begin
            if (!elem_team[it.element_id][6])
                r.status = ST_NO_TEAM;
            else if (q_elem.size() >= CAPACITY)
                r.status = ST_FULL;
            else
            begin
                // behind last queued teammate, else at tail
                pos = q_elem.size();
                for (int i = 0; i < q_team.size(); i++)
                    if (q_team[i] == elem_team[it.element_id][5:0])
                        pos = i + 1;
                q_elem.insert(pos, it.element_id);
                q_team.insert(pos, elem_team[it.element_id][5:0]);
            end
        end
        else if (it.opcode == OP_DEQ)
        begin
            if (q_elem.size() == 0)
                r.status = ST_EMPTY;
            else
            begin
                r.out_element = q_elem.pop_front();
                void'(q_team.pop_front());
                r.status = ST_DEQ_OK;
            end
        end
        return r;
    endfunction

    function automatic item_t make_item(logic [1:0] op, int eid, int tid);
        item_t it;
        it.opcode     = op;
        it.element_id = eid[9:0];
        it.team_id    = tid[5:0];
        return it;
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            item <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                expected_results.push_back(predict_team_queue(item));
            end
            if (!(push && full))
            begin
                if (pending_items.size() > 0 &&
                    $urandom_range(99, 0) >= send_idle_pct)
                begin
                    push <= 1'b1;
                    item <= pending_items.pop_front();
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor and receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop      <= 1'b0;
            hold_cnt <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, result);
                    errors++;
                end
                else
                begin
                    result_t exp_r;
                    exp_r = expected_results.pop_front();
                    if (exp_r.out_element !== result.out_element)
                    begin
                        $display("%0t: out_element expected %0d actual %0d",
                                 $time, exp_r.out_element, result.out_element);
                        errors++;
                    end
                    if (exp_r.status !== result.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_r.status, result.status);
                        errors++;
                    end
                end
            end
            // Long hold-off counted here, random idling otherwise
            if (recv_hold && hold_cnt < HOLD_CYCLES)
            begin
                hold_cnt <= hold_cnt + 1;
                pop      <= 1'b0;
            end
            else
            begin
                if (!recv_hold)
                    hold_cnt <= 0;
                pop <= ($urandom_range(99, 0) >= recv_idle_pct);
            end
        end
    end

    // Watchdog on cycles with no acceptance
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("team_grouped_queue_top regression: fail");
            $finish;
        end
    end

    task automatic drain();
        do
            @(negedge clk);
        while (pending_items.size() > 0 || push || expected_results.size() > 0);
    endtask

    task automatic add_random(int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99, 0);
            if (r < 20)
                pending_items.push_back(make_item(OP_BIND, $urandom_range(63, 0),
                                                  $urandom_range(7, 0)));
            else if (r < 25)
                pending_items.push_back(make_item(OP_BIND, $urandom_range(1023, 0),
                                                  $urandom_range(63, 0)));
            else if (r < 58)
                pending_items.push_back(make_item(OP_ENQ, $urandom_range(70, 0),
                                                  $urandom_range(63, 0)));
            else if (r < 62)
                pending_items.push_back(make_item(OP_ENQ, $urandom_range(1023, 0),
                                                  $urandom_range(63, 0)));
            else if (r < 97)
                pending_items.push_back(make_item(OP_DEQ, $urandom_range(1023, 0),
                                                  $urandom_range(63, 0)));
            else
                pending_items.push_back(make_item(2'd3, $urandom_range(1023, 0),
                                                  $urandom_range(63, 0)));
        end
    endtask

    // Stimulus
    initial
    begin
        send_idle_pct = 22;
        recv_idle_pct = 48;
        recv_hold = 1'b0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty dequeue, unbound enqueue, extremes, grouping, rebind
        pending_items.push_back(make_item(OP_DEQ, 0, 0));
        pending_items.push_back(make_item(OP_ENQ, 1023, 63));
        pending_items.push_back(make_item(2'd3, 1023, 63));
        pending_items.push_back(make_item(OP_BIND, 1023, 63));
        pending_items.push_back(make_item(OP_BIND, 0, 0));
        pending_items.push_back(make_item(OP_BIND, 5, 0));
        pending_items.push_back(make_item(OP_BIND, 682, 42));
        pending_items.push_back(make_item(OP_BIND, 341, 21));
        pending_items.push_back(make_item(OP_ENQ, 1023, 0));
        pending_items.push_back(make_item(OP_ENQ, 0, 0));
        pending_items.push_back(make_item(OP_ENQ, 682, 0));
        pending_items.push_back(make_item(OP_ENQ, 5, 0));
        pending_items.push_back(make_item(OP_ENQ, 1023, 0));
        pending_items.push_back(make_item(OP_BIND, 5, 42));
        pending_items.push_back(make_item(OP_ENQ, 5, 0));
        pending_items.push_back(make_item(OP_ENQ, 341, 0));
        for (int i = 0; i < 8; i++)
            pending_items.push_back(make_item(OP_DEQ, 0, 0));
        drain();

        // Random with idling one way, then the other
        add_random(50);
        drain();
        send_idle_pct = 48;
        recv_idle_pct = 22;
        add_random(50);
        drain();

        // Fill past capacity while the receiver holds off
        send_idle_pct = 0;
        recv_idle_pct = 0;
        pending_items.push_back(make_item(OP_BIND, 7, 3));
        for (int i = 0; i < CAPACITY + 2; i++)
            pending_items.push_back(make_item(OP_ENQ, (i % 3 == 0) ? 7 : 0, 0));
        recv_hold = 1'b1;
        wait (hold_cnt == HOLD_CYCLES);
        recv_hold = 1'b0;
        drain();

        // No idling
        add_random(30);
        drain();
        repeat (50) @(posedge clk);

        if (errors == 0 && expected_results.size() == 0)
            $display("team_grouped_queue_top regression: pass");
        else
            $display("team_grouped_queue_top regression: fail");
        $finish;
    end

endmodule
